FILE: design/vtg_pkg.sv
// shared types, constants and helpers for the virtual time generator
package vtg_pkg;

	localparam int MAX_BLOCK_LENGTH = 4096;
	localparam int CNT_W = $clog2(MAX_BLOCK_LENGTH);

	localparam logic signed [23:0] RATE_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] RATE_MIN = -24'sh800000;
	localparam logic signed [23:0] RATE_ONE = 24'sh010000;
	localparam logic signed [47:0] T48_MIN = 48'sh800000000000;
	localparam logic signed [47:0] T48_MAX = 48'sh7FFFFFFFFFFF;

	// divider numerator width: 49-bit magnitude plus up to 24 fraction bits
	localparam int DIV_N_W = 73;
	localparam int DIV_D_W = 48;

	// configuration register indexes
	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
	localparam logic [2:0] REG_MIN_TIME = 3'd1;
	localparam logic [2:0] REG_MAX_TIME = 3'd2;
	localparam logic [2:0] REG_APPROACH_SLEW = 3'd3;
	localparam logic [2:0] REG_MAX_SPEED = 3'd4;
	localparam logic [2:0] REG_MIN_SPEED = 3'd5;
	localparam logic [2:0] REG_BLOCK_LENGTH = 3'd6;

	// operations
	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_RATE_TICK = 3'd1;
	localparam logic [2:0] OP_POS_TICK = 3'd2;
	localparam logic [2:0] OP_SET_RATE = 3'd3;
	localparam logic [2:0] OP_SET_POS = 3'd4;
	localparam logic [2:0] OP_APPROACH = 3'd5;
	localparam logic [2:0] OP_TARGET = 3'd6;
	localparam logic [2:0] OP_GOTO = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_LIMITS = 2'd1;
	localparam logic [1:0] ST_DURATION = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;       // capture input word and run the first step
		logic div_start;  // launch divider
		logic div_run;    // one divider iteration
		logic finish;     // apply division result / check, present word
	} vtg_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_div;   // the operation needs a division
		logic div_done;   // division result is ready
	} vtg_stat_t;

endpackage

FILE: design/vtg_divider.sv
// iterative signed divider, one quotient bit per cycle while step is high, saturated to Q8.16
module vtg_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic step,
	input  logic signed [49:0] num,
	input  logic [4:0] frac,
	input  logic signed [47:0] den,
	output logic done,
	output logic signed [23:0] quot
);
	import vtg_pkg::*;

	localparam int CW = $clog2(DIV_N_W + 1);

	logic [DIV_N_W-1:0] n_q;
	logic [DIV_D_W:0] r_q;
	logic [DIV_D_W-1:0] d_q;
	logic [DIV_N_W-1:0] qb_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, sign_q, zero_q, dzero_q, busy_q;
	logic [DIV_D_W:0] r_sh, r_sub;
	logic [48:0] nmag;

	assign nmag = num[49] ? 49'(-num) : 49'(num);
	assign r_sh = {r_q[DIV_D_W-1:0], n_q[DIV_N_W-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	// shift-subtract loop over numerator bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(DIV_N_W);
		end else if (step && busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= DIV_N_W'({nmag, 24'd0} >> (5'd24 - frac));
			r_q <= '0;
			qb_q <= '0;
			d_q <= den[47] ? 48'(-den) : 48'(den);
			neg_q <= num[49] ^ den[47];
			sign_q <= num[49];
			zero_q <= (num == '0);
			dzero_q <= (den == '0);
		end else if (step && busy_q) begin
			n_q <= {n_q[DIV_N_W-2:0], 1'b0};
			if (!r_sub[DIV_D_W]) begin
				r_q <= r_sub;
				qb_q <= {qb_q[DIV_N_W-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				qb_q <= {qb_q[DIV_N_W-2:0], 1'b0};
			end
		end
	end

	assign done = !busy_q;

	// saturate magnitude and apply sign
	always_comb begin
		if (zero_q) quot = '0;
		else if (dzero_q) quot = sign_q ? RATE_MIN : RATE_MAX;
		else if (qb_q > DIV_N_W'(24'h800000)) quot = neg_q ? RATE_MIN : RATE_MAX;
		else if (neg_q) quot = 24'(-$signed({1'b0, qb_q[23:0]}));
		else if (qb_q[23]) quot = RATE_MAX;
		else quot = $signed(qb_q[23:0]);
	end
endmodule

FILE: design/vtg_datapath.sv
// datapath: time state, tick arithmetic, constraint logic and output word
module vtg_datapath (
	input  logic clk,
	input  logic arst_n,
	input  vtg_pkg::vtg_cmd_t cmd,
	output vtg_pkg::vtg_stat_t stat,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [47:0] cfg_data,
	input  logic [2:0] operation,
	input  logic signed [23:0] rate_value,
	input  logic signed [47:0] position_value,
	input  logic signed [31:0] duration,
	output logic signed [47:0] time_out,
	output logic [1:0] status,
	output logic target_flag,
	output logic hurry_flag,
	output logic signed [23:0] rate_out
);
	import vtg_pkg::*;

	logic [31:0] period_q;
	logic signed [47:0] min_time_q, max_time_q;
	logic [23:0] slew_q;
	logic signed [23:0] max_speed_q, min_speed_q;
	logic [12:0] blen_q;

	logic signed [47:0] vtime_q, target_q, left_q;
	logic signed [23:0] rate_q, user_q;
	logic active_q, hurry_q;
	logic [CNT_W-1:0] bcnt_q;
	logic [2:0] op_q;
	logic check_q, goto_q;
	logic signed [47:0] pos_q;

	logic signed [23:0] tick_rate;
	logic signed [56:0] prod;
	logic signed [48:0] step_d, vsum;
	logic signed [47:0] vnext, pclip;
	logic signed [48:0] tl_diff;
	logic signed [47:0] tl_next;
	logic [13:0] blen_eff;
	logic bend;
	logic pv_out;
	logic signed [49:0] div_num;
	logic [4:0] div_frac;
	logic signed [47:0] div_den;
	logic signed [23:0] quot;
	logic div_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 32'd89478;
			min_time_q <= T48_MIN;
			max_time_q <= T48_MAX;
			slew_q <= 24'd838861;
			max_speed_q <= 24'sd131072;
			min_speed_q <= 24'sd32768;
			blen_q <= 13'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_PERIOD: period_q <= cfg_data[31:0];
				REG_MIN_TIME: min_time_q <= cfg_data;
				REG_MAX_TIME: max_time_q <= cfg_data;
				REG_APPROACH_SLEW: slew_q <= cfg_data[23:0];
				REG_MAX_SPEED: max_speed_q <= cfg_data[23:0];
				REG_MIN_SPEED: min_speed_q <= cfg_data[23:0];
				REG_BLOCK_LENGTH: blen_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// tick arithmetic
	assign tick_rate = (operation == OP_RATE_TICK) ? rate_value : rate_q;
	assign prod = $signed({1'b0, period_q}) * tick_rate + 57'sd8388608;
	assign step_d = 49'(prod >>> 24);
	assign vsum = 49'(vtime_q) + step_d;

	function automatic logic signed [47:0] clip(input logic signed [48:0] v,
			input logic signed [47:0] lo, input logic signed [47:0] hi);
		if (v < 49'(lo)) return lo;
		else if (v > 49'(hi)) return hi;
		else return 48'(v);
	endfunction

	assign vnext = clip(vsum, min_time_q, max_time_q);
	assign pclip = clip(49'(position_value), min_time_q, max_time_q);
	assign tl_diff = 49'(left_q) - 49'($signed({1'b0, period_q}));
	assign tl_next = (tl_diff < 49'(T48_MIN)) ? T48_MIN : 48'(tl_diff);
	assign blen_eff = (blen_q == '0) ? 14'd1 :
		(14'(blen_q) > 14'(MAX_BLOCK_LENGTH)) ? 14'(MAX_BLOCK_LENGTH) : 14'(blen_q);
	assign bend = (14'(bcnt_q) + 14'd1) >= blen_eff;

	// divider operands come from registered state
	always_comb begin
		div_num = 50'(target_q) - 50'(vtime_q);
		div_frac = 5'd24;
		div_den = left_q;
		if (op_q == OP_APPROACH) begin
			div_num = 50'(pos_q) - 50'(vtime_q) + 50'($signed({1'b0, slew_q}));
			div_frac = 5'd16;
			div_den = 48'($signed({1'b0, slew_q}));
		end else if (goto_q) begin
			div_frac = 5'd8;
			div_den = 48'(left_q >>> 16);
		end
	end

	vtg_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .step(cmd.div_run),
		.num(div_num), .frac(div_frac), .den(div_den), .done(div_done), .quot(quot)
	);

	assign stat.need_div = check_q;
	assign stat.div_done = div_done;

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtime_q <= '0;
			rate_q <= RATE_ONE;
			user_q <= RATE_ONE;
			active_q <= 1'b0;
			hurry_q <= 1'b0;
			left_q <= '0;
			target_q <= '0;
			bcnt_q <= '0;
			op_q <= OP_TICK;
			check_q <= 1'b0;
			goto_q <= 1'b0;
			status <= ST_OK;
			pv_out <= 1'b0;
		end else if (cmd.load) begin
			op_q <= operation;
			check_q <= 1'b0;
			goto_q <= 1'b0;
			status <= ST_OK;
			pv_out <= 1'b0;
			unique case (operation)
				OP_TICK: begin
					vtime_q <= vnext;
					bcnt_q <= bend ? '0 : bcnt_q + 1'b1;
					if (active_q) begin
						left_q <= tl_next;
						if (tl_next <= 0) begin
							active_q <= 1'b0;
							hurry_q <= 1'b0;
							rate_q <= user_q;
						end else begin
							check_q <= bend;
						end
					end
				end
				OP_RATE_TICK: begin
					vtime_q <= vnext;
					bcnt_q <= bend ? '0 : bcnt_q + 1'b1;
					check_q <= bend && active_q;
				end
				OP_POS_TICK: begin
					bcnt_q <= bend ? '0 : bcnt_q + 1'b1;
					target_q <= target_q;
					pv_out <= 1'b1;
				end
				OP_SET_RATE: begin
					user_q <= rate_value;
					if (!(active_q && hurry_q)) rate_q <= rate_value;
				end
				OP_SET_POS: begin
					vtime_q <= pclip;
					check_q <= active_q;
				end
				OP_APPROACH: begin
					// numerator built from the stored position sample
					check_q <= 1'b1;
				end
				OP_TARGET: begin
					if (position_value < min_time_q || position_value > max_time_q) begin
						status <= ST_LIMITS;
					end else begin
						active_q <= 1'b1;
						target_q <= position_value;
						left_q <= 48'(duration) <<< 16;
						check_q <= 1'b1;
					end
				end
				OP_GOTO: begin
					if (duration <= 0) begin
						status <= ST_DURATION;
					end else if (position_value < min_time_q ||
							position_value > max_time_q) begin
						status <= ST_LIMITS;
					end else begin
						active_q <= 1'b1;
						hurry_q <= 1'b1;
						target_q <= position_value;
						left_q <= 48'(duration) <<< 16;
						check_q <= 1'b1;
						goto_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end else if (cmd.finish && check_q) begin
			if (op_q == OP_APPROACH || goto_q) begin
				rate_q <= quot;
			end else if (quot <= min_speed_q || quot >= max_speed_q) begin
				rate_q <= quot;
				hurry_q <= 1'b1;
			end else begin
				hurry_q <= 1'b0;
			end
		end
	end

	// approach needs the position sample as numerator; keep it aside
	always_ff @(posedge clk) begin
		if (cmd.load) pos_q <= (operation == OP_POS_TICK) ? pclip : position_value;
	end

	assign time_out = pv_out ? pos_q : vtime_q;
	assign target_flag = active_q;
	assign hurry_flag = hurry_q;
	assign rate_out = rate_q;
endmodule

FILE: design/vtg_controller.sv
// controller: sequences load, division and result hand-off
module vtg_controller (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_fire,
	input  vtg_pkg::vtg_stat_t stat,
	output vtg_pkg::vtg_cmd_t cmd,
	output logic in_ready,
	output logic out_valid
);
	import vtg_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DECIDE = 5'b00010,
		S_DIV   = 5'b00100,
		S_FIN   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) state_d = S_DECIDE;
			S_DECIDE: state_d = stat.need_div ? S_DIV : S_OUT;
			S_DIV: if (stat.div_done) state_d = S_FIN;
			S_FIN: state_d = S_OUT;
			S_OUT: if (out_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign cmd.load = in_fire;
	assign cmd.div_start = (state_q == S_DECIDE) && stat.need_div;
	assign cmd.div_run = (state_q == S_DIV);
	assign cmd.finish = (state_q == S_FIN);
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
endmodule

FILE: design/virtual_time_generator_top.sv
// Virtual time generator: one result word per input word.
// Words that divide run 73 iterations of the shift-subtract divider before the result.
// One word at a time: a new word is accepted only once the last result has been taken.
// Reset: asynchronous, active low; state and registers to their defaults.
module virtual_time_generator_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] operation,
	input  logic signed [23:0] rate_value,
	input  logic signed [47:0] position_value,
	input  logic signed [31:0] duration,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [47:0] time_out,
	output logic [1:0] status,
	output logic target_flag,
	output logic hurry_flag,
	output logic signed [23:0] rate_out,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [47:0] cfg_data
);
	import vtg_pkg::*;

	vtg_cmd_t cmd;
	vtg_stat_t stat;
	logic in_fire, out_fire;

	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// sequencing
	vtg_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.stat(stat), .cmd(cmd), .in_ready(in_ready), .out_valid(out_valid)
	);

	// arithmetic and state
	vtg_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.operation(operation), .rate_value(rate_value),
		.position_value(position_value), .duration(duration),
		.time_out(time_out), .status(status), .target_flag(target_flag),
		.hurry_flag(hurry_flag), .rate_out(rate_out)
	);

`ifndef NO_ASSERTIONS
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready and valid together");
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("word dropped");
	a_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready) else $error("second word taken");
`endif
endmodule

FILE: sim/virtual_time_generator_top_tb.sv
// self-checking testbench for the virtual time generator
module virtual_time_generator_top_tb;
	import vtg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// expected result word
	typedef struct {
		logic signed [47:0] tout;
		logic [1:0] st;
		logic tgt;
		logic hur;
		logic signed [23:0] rate;
	} vt_result_t;

	// predictor of the generator plus the store of pending results
	class vt_scoreboard;
		logic [31:0] period;
		logic signed [47:0] tmin, tmax;
		logic [23:0] slew;
		logic signed [23:0] spd_hi, spd_lo;
		logic [12:0] blen;
		logic signed [47:0] vt, tgt_time, left;
		logic signed [23:0] rate, urate;
		logic tgt_on, hur;
		int unsigned bcount;
		vt_result_t pending[$];
		int errors;
		int checked;

		function void reset_state();
			period = 32'd89478; tmin = T48_MIN; tmax = T48_MAX;
			slew = 24'd838861; spd_hi = 24'sd131072; spd_lo = 24'sd32768;
			blen = 13'd64; vt = 0; rate = RATE_ONE; urate = RATE_ONE;
			tgt_on = 0; hur = 0; left = 0; tgt_time = 0; bcount = 0;
			pending.delete();
		endfunction

		function void write_reg(logic [2:0] idx, logic [47:0] d);
			case (idx)
				REG_SAMPLE_PERIOD: period = d[31:0];
				REG_MIN_TIME: tmin = d;
				REG_MAX_TIME: tmax = d;
				REG_APPROACH_SLEW: slew = d[23:0];
				REG_MAX_SPEED: spd_hi = d[23:0];
				REG_MIN_SPEED: spd_lo = d[23:0];
				REG_BLOCK_LENGTH: blen = d[12:0];
				default: ;
			endcase
		endfunction

		function logic signed [47:0] clip(logic signed [63:0] v);
			if (v < tmin) return tmin;
			if (v > tmax) return tmax;
			return v[47:0];
		endfunction

		// (num << sh) / den truncated, saturated to rate range
		function logic signed [23:0] rate_div(logic signed [63:0] num, int sh,
				logic signed [63:0] den);
			logic [127:0] n, d, q;
			logic neg;
			neg = (num < 0) != (den < 0);
			if (num == 0) return 0;
			if (den == 0) return num < 0 ? RATE_MIN : RATE_MAX;
			n = num < 0 ? 128'(-num) : 128'(num);
			d = den < 0 ? 128'(-den) : 128'(den);
			q = (n << sh) / d;
			if (neg) return q > 128'd8388608 ? RATE_MIN : 24'(-q);
			return q > 128'd8388607 ? RATE_MAX : 24'(q);
		endfunction

		function void speed_check();
			logic signed [23:0] avg;
			if (!tgt_on) return;
			avg = rate_div(64'(tgt_time) - 64'(vt), 24, 64'(left));
			if (avg <= spd_lo || avg >= spd_hi) begin
				rate = avg; hur = 1;
			end else hur = 0;
		endfunction

		function void advance(logic signed [23:0] r);
			logic signed [63:0] p;
			p = $signed({32'd0, period}) * 64'(r);
			p = (p + 64'sd8388608) >>> 24;
			vt = clip(64'(vt) + p);
		endfunction

		function logic at_block_end();
			int unsigned len;
			len = blen == 0 ? 1 : (blen > MAX_BLOCK_LENGTH ? MAX_BLOCK_LENGTH : blen);
			if (bcount + 1 >= len) begin
				bcount = 0; return 1;
			end
			bcount++;
			return 0;
		endfunction

		// note an accepted input word and queue its result
		function void note_input(logic [2:0] op, logic signed [23:0] rv,
				logic signed [47:0] pv, logic signed [31:0] dur);
			vt_result_t e;
			logic signed [63:0] tl;
			e.st = ST_OK;
			case (op)
				OP_TICK: begin
					advance(rate);
					if (tgt_on) begin
						tl = 64'(left) - 64'(period);
						left = tl < 64'(T48_MIN) ? T48_MIN : tl[47:0];
						if (left <= 0) begin
							tgt_on = 0; hur = 0; rate = urate;
						end
					end
					if (at_block_end()) speed_check();
				end
				OP_RATE_TICK: begin
					advance(rv);
					if (at_block_end()) speed_check();
				end
				OP_POS_TICK: void'(at_block_end());
				OP_SET_RATE: begin
					urate = rv;
					if (!(tgt_on && hur)) rate = rv;
				end
				OP_SET_POS: begin
					vt = clip(64'(pv));
					speed_check();
				end
				OP_APPROACH:
					rate = rate_div(64'(pv) - 64'(vt) + 64'(slew), 16, 64'(slew));
				OP_TARGET: begin
					if (pv < tmin || pv > tmax) e.st = ST_LIMITS;
					else begin
						tgt_on = 1; tgt_time = pv; left = 48'(64'(dur) * 65536);
						speed_check();
					end
				end
				default: begin
					if (dur <= 0) e.st = ST_DURATION;
					else if (pv < tmin || pv > tmax) e.st = ST_LIMITS;
					else begin
						tgt_on = 1; hur = 1; tgt_time = pv;
						left = 48'(64'(dur) * 65536);
						rate = rate_div(64'(pv) - 64'(vt), 8, 64'(dur));
					end
				end
			endcase
			e.tout = op == OP_POS_TICK ? clip(64'(pv)) : vt;
			e.tgt = tgt_on; e.hur = hur; e.rate = rate;
			pending.push_back(e);
		endfunction

		function void report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch word %0d %s: got %0h want %0h", checked, what, got, want);
			errors++;
		endfunction

		// compare a result word with the oldest expectation
		function void check_result(logic signed [47:0] t, logic [1:0] s, logic tf,
				logic hf, logic signed [23:0] r);
			vt_result_t e;
			if (pending.size() == 0) begin
				report("unexpected word", 0, 0);
				return;
			end
			e = pending.pop_front();
			if (t !== e.tout) report("time_out", 64'(t), 64'(e.tout));
			if (s !== e.st) report("status", 64'(s), 64'(e.st));
			if (tf !== e.tgt) report("target_flag", 64'(tf), 64'(e.tgt));
			if (hf !== e.hur) report("hurry_flag", 64'(hf), 64'(e.hur));
			if (r !== e.rate) report("rate_out", 64'(r), 64'(e.rate));
			checked++;
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_we;
	logic [2:0] operation, cfg_index;
	logic signed [23:0] rate_value, rate_out;
	logic signed [47:0] position_value, time_out;
	logic signed [31:0] duration;
	logic [1:0] status;
	logic target_flag, hurry_flag;
	logic [47:0] cfg_data;

	vt_scoreboard sb;
	int idle_cycles;
	int stall_mode;
	bit done;
	int n_sent, n_ops[8];

	virtual_time_generator_top dut (.*);

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// model accepted words and check results at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(operation, rate_value, position_value, duration);
			if (out_valid && out_ready)
				sb.check_result(time_out, status, target_flag, hurry_flag, rate_out);
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("watchdog expired, %0d words outstanding", sb.pending.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: own stall pattern, one long hold-off when asked
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			case (stall_mode)
				0: out_ready <= 1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 1) != 0);
				default: out_ready <= 0;
			endcase
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [47:0] d);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// wait until every expected word has come, plus the divider latency
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic send(logic [2:0] op, logic signed [23:0] rv,
			logic signed [47:0] pv, logic signed [31:0] dur);
		@(negedge clk);
		in_valid <= 1; operation <= op; rate_value <= rv;
		position_value <= pv; duration <= dur;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid <= 0;
		n_sent++; n_ops[op]++;
	endtask

	function automatic logic signed [47:0] rnd48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// random word: mostly ticks, the other operations with random positions and durations
	task automatic random_word();
		logic [2:0] op;
		logic signed [47:0] pv;
		logic signed [31:0] dur;
		int k;
		k = $urandom_range(0, 99);
		if (k < 45) op = OP_TICK;
		else if (k < 55) op = OP_RATE_TICK;
		else op = 3'($urandom_range(2, 7));
		case ($urandom_range(0, 3))
			0: pv = rnd48();
			1: pv = sb.vt + 48'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
			default: pv = sb.vt + 48'($signed($urandom_range(0, 1 << 22)));
		endcase
		case ($urandom_range(0, 4))
			0: dur = $urandom();
			1: dur = -$signed(32'($urandom_range(0, 5)));
			default: dur = $urandom_range(1, 1 << 12);
		endcase
		send(op, 24'($urandom()), pv, dur);
	endtask

	task automatic random_burst(int count);
		int left;
		left = count;
		while (left > 0) begin
			for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
				random_word();
				left--;
			end
			if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 40)) @(negedge clk);
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		sb.errors = 0; sb.checked = 0;
		done = 0; n_sent = 0; stall_mode = 0; idle_cycles = 0;
		in_valid = 0; operation = OP_TICK; rate_value = 0; position_value = 0;
		duration = 0; cfg_we = 0; cfg_index = REG_SAMPLE_PERIOD; cfg_data = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: every operation, field extremes and the special cases
		send(OP_TICK, 0, 0, 0);
		send(OP_RATE_TICK, RATE_MAX, 0, 0);
		send(OP_RATE_TICK, RATE_MIN, 0, 0);
		send(OP_POS_TICK, 0, T48_MAX, 0);
		send(OP_POS_TICK, 0, T48_MIN, 0);
		send(OP_SET_RATE, RATE_MIN, 0, 0);
		send(OP_SET_RATE, RATE_ONE, 0, 0);
		send(OP_SET_POS, 0, 48'sd1 << 30, 0);
		send(OP_APPROACH, 0, T48_MAX, 0);
		send(OP_APPROACH, 0, T48_MIN, 0);
		send(OP_TARGET, 0, 48'sd1 << 32, 32'sd65536);
		send(OP_TICK, 0, 0, 0);
		// zero duration saturates the speed
		send(OP_TARGET, 0, 48'sd1 << 33, 0);
		send(OP_GOTO, 0, 48'sd1 << 33, 0);
		send(OP_GOTO, 0, 48'sd1 << 33, 32'h80000000);
		send(OP_GOTO, 0, 48'sd1 << 34, 32'sh7FFFFFFF);
		send(OP_GOTO, 0, -48'sd5, 32'sd1);
		send(OP_SET_RATE, RATE_MAX, 0, 0);
		drain();

		// narrow limits: targets outside are refused, ticks clip
		cfg_write(REG_MIN_TIME, 48'h0000_0000_0000);
		cfg_write(REG_MAX_TIME, 48'h0000_1000_0000);
		cfg_write(REG_SAMPLE_PERIOD, 32'hFFFFFFFF);
		send(OP_TARGET, 0, T48_MAX, 32'sd10);
		send(OP_GOTO, 0, T48_MIN, 32'sd10);
		send(OP_RATE_TICK, RATE_MAX, 0, 0);
		send(OP_RATE_TICK, RATE_MIN, 0, 0);
		send(OP_SET_POS, 0, T48_MIN, 0);
		drain();

		// crossed limits, tiny slew, one-tick blocks, odd speed window
		cfg_write(REG_MIN_TIME, 48'h0000_2000_0000);
		cfg_write(REG_MAX_TIME, 48'h0000_1000_0000);
		cfg_write(REG_APPROACH_SLEW, 48'd1);
		cfg_write(REG_BLOCK_LENGTH, 48'd1);
		cfg_write(REG_MAX_SPEED, 48'h00_800000);
		cfg_write(REG_MIN_SPEED, 48'h00_7FFFFF);
		cfg_write(REG_SAMPLE_PERIOD, 48'd1);
		random_burst(60);
		drain();

		// open limits, long blocks, extreme slew
		cfg_write(REG_MIN_TIME, 48'h8000_0000_0000);
		cfg_write(REG_MAX_TIME, 48'h7FFF_FFFF_FFFF);
		cfg_write(REG_APPROACH_SLEW, 48'hFFFFFF);
		cfg_write(REG_BLOCK_LENGTH, 48'd4096);
		cfg_write(REG_MAX_SPEED, 48'd131072);
		cfg_write(REG_MIN_SPEED, 48'd32768);
		cfg_write(REG_SAMPLE_PERIOD, 48'd89478);
		stall_mode = 1;
		random_burst(200);

		// long hold-off while the sender keeps offering
		fork
			begin
				stall_mode = 3;
				repeat (400) @(negedge clk);
				stall_mode = 2;
			end
			random_burst(40);
		join
		drain();

		// small blocks and out-of-range block length, mixed stalls
		cfg_write(REG_BLOCK_LENGTH, 48'h1FFF);
		cfg_write(REG_SAMPLE_PERIOD, 48'h0100_0000);
		random_burst(150);
		drain();
		cfg_write(REG_BLOCK_LENGTH, 48'd0);
		cfg_write(REG_MAX_SPEED, 48'd100000);
		cfg_write(REG_MIN_SPEED, 48'd40000);
		cfg_write(REG_APPROACH_SLEW, 48'd838861);
		stall_mode = 0;
		random_burst(200);
		drain();
		cfg_write(REG_BLOCK_LENGTH, 48'd3);
		stall_mode = 1;
		random_burst(170);
		drain();

		done = 1;
		$display("sent %0d words, checked %0d results", n_sent, sb.checked);
		$display("ops tick %0d rate %0d pos %0d setrate %0d setpos %0d appr %0d tgt %0d goto %0d",
			n_ops[0], n_ops[1], n_ops[2], n_ops[3], n_ops[4], n_ops[5], n_ops[6],
			n_ops[7]);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
